@@ hdl/notch_biquad_filter_core_assert.svh @@
// Assertion macros for the notch biquad filter core.
// Each use expects clk_i and rst_ni in scope.
`ifndef NOTCH_BIQUAD_FILTER_CORE_ASSERT_SVH
`define NOTCH_BIQUAD_FILTER_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define NBQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nbq: same-cycle check failed");

// consequent checked in the following cycle
`define NBQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nbq: next-cycle check failed");

`endif

@@ hdl/nbq_pkg.sv @@
// ----------------------------------------------------------------------------
// nbq_pkg
// Shared constants and types of the notch biquad filter core.
// ----------------------------------------------------------------------------
package nbq_pkg;

  localparam int unsigned SAMPLE_BITS_DEF    = 16;
  localparam int unsigned COEF_FRAC_BITS     = 15;
  localparam int unsigned COEF_W             = 18;
  localparam int unsigned STATE_W            = 36;
  localparam int unsigned CFG_IDX_W          = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 2'd0,
    REG_B1 = 2'd1,
    REG_A1 = 2'd2,
    REG_A2 = 2'd3
  } cfg_reg_e;

endpackage

@@ hdl/nbq_in_if.sv @@
// ----------------------------------------------------------------------------
// nbq_in_if
// Input sample channel: valid/ready handshake with one signed sample per word.
// ----------------------------------------------------------------------------
interface nbq_in_if #(
  parameter int unsigned SampleBits = nbq_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_in;

  modport source (output valid, output sample_in, input  ready);
  modport sink   (input  valid, input  sample_in, output ready);
endinterface

@@ hdl/nbq_out_if.sv @@
// ----------------------------------------------------------------------------
// nbq_out_if
// Output sample channel: filtered sample plus saturation flag per word.
// ----------------------------------------------------------------------------
interface nbq_out_if #(
  parameter int unsigned SampleBits = nbq_pkg::SAMPLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample_out;
  logic                         clipped;

  modport source (output valid, output sample_out, output clipped, input  ready);
  modport sink   (input  valid, input  sample_out, input  clipped, output ready);
endinterface

@@ hdl/notch_biquad_filter_core.sv @@
// ----------------------------------------------------------------------------
// notch_biquad_filter_core
// Direct form I biquad notch filter, Q3.F coefficients, b2 tied to b0.
// ----------------------------------------------------------------------------
// Takes one sample word per clock and gives one filtered word per clock for
// as long as the output side is ready; an accepted word is held in the input
// register until the result register is free or being emptied, and its result
// is then loaded into the result register for the output side to take. The
// whole recursion y[n] = b0*x[n] + b1*x[n-1] + b0*x[n-2] - (a1*y[n-1] >> F)
// - (a2*y[n-2] >> F) runs combinationally between those registers: three
// 18xSampleBits and two 18x36 multiplies, a five-term sum and the saturation
// of y to 36 bits; that path sets the clock. sample_out is y truncated toward
// zero and saturated to SampleBits; clipped flags the saturation. The user
// must write coefficients via cfg only while idle; the core does not enforce it.
module notch_biquad_filter_core #(
  parameter int unsigned SampleBits   = nbq_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nbq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nbq_pkg::COEF_W-1:0]     cfg_data_i,
  nbq_in_if.sink                         in_i,
  nbq_out_if.source                      out_o
);
  import nbq_pkg::*;

  localparam int unsigned FF_W   = COEF_W + SampleBits;
  localparam int unsigned FB_W   = COEF_W + STATE_W;
  localparam int unsigned FBS_W  = FB_W - COEF_FRAC_BITS;
  localparam int unsigned MAX_W0 = (FF_W > FBS_W) ? FF_W : FBS_W;
  localparam int unsigned MAX_W1 = (MAX_W0 > STATE_W) ? MAX_W0 : STATE_W;
  localparam int unsigned ACC_W  = MAX_W1 + 3;
  localparam int unsigned TR_W   = STATE_W + 1;

  localparam logic signed [ACC_W-1:0] ST_MAX = ACC_W'({1'b0, {(STATE_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [TR_W-1:0]  S_MAX  = TR_W'({1'b0, {(SampleBits-1){1'b1}}});
  localparam logic signed [TR_W-1:0]  S_MIN  = ~S_MAX;
  localparam logic [TR_W-1:0]         RND    = TR_W'({COEF_FRAC_BITS{1'b1}});
  localparam logic signed [SampleBits-1:0] S_MAX_N = S_MAX[SampleBits-1:0];
  localparam logic signed [SampleBits-1:0] S_MIN_N = S_MIN[SampleBits-1:0];
  localparam logic [COEF_W-1:0]       B0_RST = COEF_W'(64'd1 << COEF_FRAC_BITS);

  // coefficients
  logic signed [COEF_W-1:0] coef_b0_q, coef_b1_q, coef_a1_q, coef_a2_q;

  // input register
  logic                         s1_valid_q, s1_valid_d;
  logic signed [SampleBits-1:0] x_q;

  // filter history
  logic signed [SampleBits-1:0] xp1_q, xp2_q;
  logic signed [STATE_W-1:0]    y1_q, y2_q;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic signed [SampleBits-1:0] sample_out_q, sample_out_d;
  logic                         clipped_q, clipped_d;

  logic in_accept;
  logic s1_adv;

  logic signed [FF_W-1:0]    p_b0x, p_b1x, p_b0x2;
  logic signed [FB_W-1:0]    p_a1y, p_a2y;
  logic signed [ACC_W-1:0]   acc;
  logic signed [STATE_W-1:0] y_sat;
  logic signed [TR_W-1:0]    tr_in, tr;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_accept  = in_i.valid && in_i.ready;

  assign s1_valid_d  = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  // recursion: products, sum, state saturation, truncation toward zero, output saturation
  always_comb begin
    p_b0x  = coef_b0_q * x_q;
    p_b1x  = coef_b1_q * xp1_q;
    p_b0x2 = coef_b0_q * xp2_q;
    p_a1y  = coef_a1_q * y1_q;
    p_a2y  = coef_a2_q * y2_q;

    acc = ACC_W'(p_b0x) + ACC_W'(p_b1x) + ACC_W'(p_b0x2)
        - ACC_W'(p_a1y >>> COEF_FRAC_BITS) - ACC_W'(p_a2y >>> COEF_FRAC_BITS);

    if (acc > ST_MAX) begin
      y_sat = STATE_W'(ST_MAX);
    end else if (acc < ST_MIN) begin
      y_sat = STATE_W'(ST_MIN);
    end else begin
      y_sat = STATE_W'(acc);
    end

    // bias negatives so the arithmetic shift truncates toward zero
    tr_in = TR_W'(y_sat) + (y_sat[STATE_W-1] ? RND : '0);
    tr    = tr_in >>> COEF_FRAC_BITS;

    if (tr > S_MAX) begin
      sample_out_d = S_MAX_N;
      clipped_d    = 1'b1;
    end else if (tr < S_MIN) begin
      sample_out_d = S_MIN_N;
      clipped_d    = 1'b1;
    end else begin
      sample_out_d = tr[SampleBits-1:0];
      clipped_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      xp1_q       <= '0;
      xp2_q       <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
      coef_b0_q   <= B0_RST;
      coef_b1_q   <= '0;
      coef_a1_q   <= '0;
      coef_a2_q   <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        xp1_q <= x_q;
        xp2_q <= xp1_q;
        y1_q  <= y_sat;
        y2_q  <= y1_q;
      end
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_B0:  coef_b0_q <= cfg_data_i;
          REG_B1:  coef_b1_q <= cfg_data_i;
          REG_A1:  coef_a1_q <= cfg_data_i;
          REG_A2:  coef_a2_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      x_q <= in_i.sample_in;
    end
    if (s1_adv) begin
      sample_out_q <= sample_out_d;
      clipped_q    <= clipped_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = sample_out_q;
  assign out_o.clipped    = clipped_q;

`include "notch_biquad_filter_core_assert.svh"

  `NBQ_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_q)
  `NBQ_ASSERT_SAME(a_stall_only_when_full, !in_i.ready, s1_valid_q && out_valid_q && !out_o.ready)
  `NBQ_ASSERT_SAME(a_clip_at_rail, out_valid_q && clipped_q, sample_out_q == S_MAX_N || sample_out_q == S_MIN_N)
  `NBQ_ASSERT_NEXT(a_history_shift, s1_adv, xp1_q == $past(x_q) && y2_q == $past(y1_q))

endmodule

@@ bench/notch_biquad_filter_core_tb.sv @@
// ----------------------------------------------------------------------------
// notch_biquad_filter_core_tb
// Self-checking bench for the notch biquad filter core.
// ----------------------------------------------------------------------------
// A short directed table is walked first. It covers the sample extremes after
// reset, truncation toward zero, and overflow of the feedback state at both
// coefficient extremes. Random phases follow, each with a new coefficient set:
// stable notch designs, full-range values, extremes and small values. A local
// fixed-point filter model predicts each output word the table does not give.
// Both sides of the stream idle at random. One phase runs with no idling,
// and one phase holds the output off for a long stretch so the core backs up.
module notch_biquad_filter_core_tb;
  import nbq_pkg::*;

  localparam int unsigned SW           = SAMPLE_BITS_DEF;
  localparam int unsigned FRAC         = COEF_FRAC_BITS;
  localparam longint      STATE_MAX    = (64'sd1 <<< (STATE_W - 1)) - 1;
  localparam longint      STATE_MIN    = -STATE_MAX - 1;
  localparam longint      SMP_MAX      = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint      SMP_MIN      = -SMP_MAX - 1;
  localparam int          IDLE_PCT     = 19;
  localparam int          HOLD_CYCLES  = 60;
  localparam int          DRAIN_CYCLES = 6;
  localparam int          NUM_PHASES   = 8;
  localparam int          PHASE_WORDS  = 100;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                kind;
    cfg_reg_e                 reg_idx;
    logic signed [COEF_W-1:0] coef;
    logic signed [SW-1:0]     sample;
    bit                       typed;
    logic signed [SW-1:0]     exp_sample;
    logic                     exp_clipped;
  } dir_row_t;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 clipped;
  } filt_word_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  cfg_reg_e             cfg_idx;
  logic [COEF_W-1:0]    cfg_data;

  nbq_in_if  #(.SampleBits(SW)) in_bus ();
  nbq_out_if #(.SampleBits(SW)) out_bus ();

  notch_biquad_filter_core #(
    .SampleBits  (SW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_bus),
    .out_o     (out_bus)
  );

  // filter model state
  longint m_b0 = 64'sd1 <<< FRAC;
  longint m_b1 = 0;
  longint m_a1 = 0;
  longint m_a2 = 0;
  longint m_x1 = 0;
  longint m_x2 = 0;
  longint m_y1 = 0;
  longint m_y2 = 0;

  filt_word_t expected_words[$];
  dir_row_t   dir_rows[$];
  int         error_count = 0;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void set_coef(cfg_reg_e r, logic signed [COEF_W-1:0] v);
    case (r)
      REG_B0: m_b0 = v;
      REG_B1: m_b1 = v;
      REG_A1: m_a1 = v;
      REG_A2: m_a2 = v;
      default: ;
    endcase
  endfunction

  // one step of the direct form I recursion, updating the model state
  function automatic filt_word_t filter_step(logic signed [SW-1:0] x);
    filt_word_t w;
    longint     xl;
    longint     acc;
    longint     q;
    xl  = x;
    acc = m_b0 * xl + m_b1 * m_x1 + m_b0 * m_x2;
    acc = acc - ((m_a1 * m_y1) >>> FRAC);
    acc = acc - ((m_a2 * m_y2) >>> FRAC);
    if (acc > STATE_MAX) acc = STATE_MAX;
    if (acc < STATE_MIN) acc = STATE_MIN;
    q = (acc >= 0) ? (acc >>> FRAC) : -((-acc) >>> FRAC);
    w.clipped = 1'b0;
    if (q > SMP_MAX) begin
      q = SMP_MAX;
      w.clipped = 1'b1;
    end else if (q < SMP_MIN) begin
      q = SMP_MIN;
      w.clipped = 1'b1;
    end
    w.sample = q[SW-1:0];
    m_y2 = m_y1;
    m_y1 = acc;
    m_x2 = m_x1;
    m_x1 = xl;
    return w;
  endfunction

  task automatic report_mismatch(string field, longint exp_v, longint got_v);
    $display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, exp_v, got_v);
    error_count++;
  endtask

  task automatic check_word();
    filt_word_t e;
    if (expected_words.size() == 0) begin
      $display("unexpected output word at %0t: %0d", $realtime, out_bus.sample_out);
      error_count++;
    end else begin
      e = expected_words.pop_front();
      if (out_bus.sample_out !== e.sample)
        report_mismatch("sample_out", e.sample, out_bus.sample_out);
      if (out_bus.clipped !== e.clipped)
        report_mismatch("clipped", e.clipped, out_bus.clipped);
    end
  endtask

  // output side: random stalls, plus a long hold when asked
  initial begin : sink_side
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) check_word();
      if (hold_req && !hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_word(logic signed [SW-1:0] x, bit typed, filt_word_t typed_w);
    filt_word_t w;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= x;
    do @(posedge clk_i); while (!in_bus.ready);
    w = filter_step(x);
    expected_words.push_back(typed ? typed_w : w);
  endtask

  task automatic drain_pipe();
    in_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e r, logic signed [COEF_W-1:0] v);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v;
    set_coef(r, v);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic add_sample(logic signed [SW-1:0] x);
    dir_row_t r;
    r = '{ROW_SAMPLE, REG_B0, '0, x, 1'b0, '0, 1'b0};
    dir_rows.push_back(r);
  endtask

  task automatic add_typed(logic signed [SW-1:0] x, logic signed [SW-1:0] e, logic c);
    dir_row_t r;
    r = '{ROW_SAMPLE, REG_B0, '0, x, 1'b1, e, c};
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg(cfg_reg_e g, logic signed [COEF_W-1:0] v);
    dir_row_t r;
    r = '{ROW_CFG, g, v, '0, 1'b0, '0, 1'b0};
    dir_rows.push_back(r);
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return SW'($urandom);
    if (roll < 50) begin
      case ($urandom_range(0, 4))
        0: return 16'sh7fff;
        1: return 16'sh8000;
        2: return 16'sd0;
        3: return -16'sd1;
        default: return 16'sd1;
      endcase
    end
    return SW'(int'($urandom_range(0, 4000)) - 2000);
  endfunction

  function automatic logic signed [COEF_W-1:0] extreme_coef();
    case ($urandom_range(0, 2))
      0: return 18'sh20000;
      1: return 18'sh1ffff;
      default: return 18'sd0;
    endcase
  endfunction

  initial begin : stimulus
    filt_word_t               tw;
    logic signed [COEF_W-1:0] coefs[4];
    int                       span;
    rst_ni           <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_B0;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.sample_in <= '0;

    // reset coefficients give y = x[n] + x[n-2]
    add_typed(16'sh7fff, 16'sh7fff, 1'b0);
    add_typed(16'sh8000, 16'sh8000, 1'b0);
    add_typed(16'sh7fff, 16'sh7fff, 1'b1);
    add_typed(16'sh8000, 16'sh8000, 1'b1);
    add_typed(16'sd0,    16'sh7fff, 1'b0);
    add_typed(16'sd0,    16'sh8000, 1'b0);
    add_typed(16'sd1,    16'sd1,    1'b0);
    // half gain: negative fractions truncate toward zero
    add_cfg(REG_B0, 18'sd16384);
    add_sample(-16'sd3);
    add_sample(16'sd3);
    add_sample(-16'sd1);
    // runaway feedback saturates the state high
    add_cfg(REG_B0, 18'sh1ffff);
    add_cfg(REG_B1, 18'sh1ffff);
    add_cfg(REG_A1, 18'sh20000);
    for (int i = 0; i < 6; i++) add_sample(16'sh7fff);
    // and low
    add_cfg(REG_B0, 18'sh20000);
    add_cfg(REG_B1, 18'sh20000);
    add_cfg(REG_A2, 18'sh1ffff);
    for (int i = 0; i < 6; i++) add_sample(16'sh7fff);
    add_sample(16'sh8000);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_pipe();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].coef);
      end else begin
        tw.sample  = dir_rows[i].exp_sample;
        tw.clipped = dir_rows[i].exp_clipped;
        send_word(dir_rows[i].sample, dir_rows[i].typed, tw);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pipe();
      case (p % 4)
        0: begin
          // stable notch: |a2| < 1, |a1| < 1 + a2
          coefs[3] = COEF_W'($urandom_range(26000, 32000));
          span     = 32768 + int'(coefs[3]) - 1500;
          coefs[2] = COEF_W'(int'($urandom_range(0, 2 * span)) - span);
          coefs[0] = COEF_W'($urandom_range(16384, 32768));
          coefs[1] = coefs[2];
        end
        1: foreach (coefs[k]) coefs[k] = COEF_W'($urandom);
        2: foreach (coefs[k]) coefs[k] = extreme_coef();
        default: foreach (coefs[k]) coefs[k] = COEF_W'(int'($urandom_range(0, 16383)) - 8192);
      endcase
      if (p == 5) coefs = '{18'sd32768, 18'sd0, 18'sd0, 18'sd0};
      for (int k = 0; k < 4; k++) write_reg(cfg_reg_e'(k), coefs[k]);
      calm = (p == 4);
      if (p == 3) hold_req = 1'b1;
      tw = '{'0, 1'b0};
      for (int n = 0; n < PHASE_WORDS; n++) send_word(rand_sample(), 1'b0, tw);
    end
    calm = 1'b0;

    drain_pipe();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
